// File: sv/bpds_pkg.sv
// ----------------------------------------------------------------------------
// bpds_pkg
// Types, constants and helpers shared by the baud prescaler divisor search.
// ----------------------------------------------------------------------------
package bpds_pkg;

    localparam int DEFAULT_CLOCK_HZ = 48000000;

    localparam int RATE_W  = 24;
    localparam int ACH_W   = 22;
    localparam int CODE_W  = 8;
    localparam int DIV_W   = 9;
    localparam int PS_W    = 2;
    localparam int IDX_W   = 2;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 40;

    // quotient probe bits: a set probe bit marks an out-of-range quotient
    localparam int DIV_PROBE = 10;
    localparam int ACH_PROBE = 22;
    localparam int QUO_W     = ACH_PROBE + 1;
    localparam int STEP_W    = 5;
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DIV_PROBE + 1);
    localparam logic [STEP_W-1:0] ACH_STEPS = STEP_W'(ACH_PROBE + 1);

    // widest aligned divisor: rate << (12 + DIV_PROBE)
    localparam int SH_W = RATE_W + 12 + DIV_PROBE;

    localparam logic [IDX_W-1:0] REG_RATE_MIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_RATE_MAX = 2'd1;

    localparam logic [RATE_W-1:0] RATE_MIN_RST = 24'd50;
    localparam logic [RATE_W-1:0] RATE_MAX_RST = 24'd3000000;

    localparam logic [CODE_W-1:0] PS_FLAG  = 8'h80;
    localparam logic [DIV_W:0]    DIV_SPAN = 10'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_ACH_LOAD,
        ST_ACH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    // log2 of the prescaler factor 2^(12-3*ps)
    function automatic logic [3:0] ps_shift(input logic [PS_W-1:0] ps);
        logic [3:0] s;
        case (ps)
            2'd3:    s = 4'd3;
            2'd2:    s = 4'd6;
            2'd1:    s = 4'd9;
            default: s = 4'd12;
        endcase
        return s;
    endfunction

endpackage

// File: sv/baud_prescaler_divisor_search.sv
// ----------------------------------------------------------------------------
// baud_prescaler_divisor_search
// Finds prescaler and divisor register bytes for a requested baud rate.
//
// s_axis carries one requested rate per transaction (tdata[23:0]). The block
// checks it against rate_minimum and rate_maximum, set through the cfg write
// port (index 0 minimum, index 1 maximum; other indexes are ignored), then
// tries prescalers 3 down to 0 and keeps the first rounded divisor in 2..256.
// m_axis returns one result per request: status, prescaler code, divisor
// code and achieved rate.
// One item at a time: a rejected rate goes to the output register without a
// division, each prescaler tried runs the shared bit-serial divider once, and
// the achieved rate takes one more run, at one quotient bit per cycle.
// s_axis_tready is high while no item is in work; a finished result waits in
// the output register while the next request is taken, and the search stalls
// only when a new result finds that register still held by the receiver.
// Reset clears the registers to minimum 50 and maximum 3000000 and empties
// the output register.
// ----------------------------------------------------------------------------
module baud_prescaler_divisor_search
    import bpds_pkg::*;
#(
    parameter int CLOCK_HZ = DEFAULT_CLOCK_HZ
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // requested_rate[23:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // status[0], prescaler_code[8:1], divisor_code[16:9], achieved_rate[38:17]
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [RATE_W-1:0] cfg_data
);

    localparam int CLKW = $clog2(CLOCK_HZ + 1);
    localparam int NW   = ((CLKW > RATE_W + 11) ? CLKW : RATE_W + 11) + 1;
    localparam logic [NW-1:0] CLK_NUM = NW'(CLOCK_HZ);

    state_t              state_reg, state_next;
    logic [RATE_W-1:0]   min_reg;
    logic [RATE_W-1:0]   max_reg;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [PS_W-1:0]     ps_reg, ps_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [ACH_W-1:0]    ach_reg, ach_next;
    logic                fail_reg, fail_next;
    logic                ovalid_reg, ovalid_next;
    logic [OUT_W-1:0]    odata_reg, odata_next;

    div_req_t            req;
    logic [NW-1:0]       numer;
    logic [SH_W-1:0]     dsh;
    logic                done;
    logic [QUO_W-1:0]    quo;
    logic [3:0]          sft;
    logic                in_ok;
    logic                fit;
    logic [DIV_W:0]      dcode;

    bpds_div #(
        .NW (NW),
        .SW (SH_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .numer (numer),
        .dsh   (dsh),
        .done  (done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= RATE_MIN_RST;
            max_reg <= RATE_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RATE_MIN: min_reg <= cfg_data;
                REG_RATE_MAX: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg  <= rate_next;
        ps_reg    <= ps_next;
        div_reg   <= div_next;
        ach_reg   <= ach_next;
        fail_reg  <= fail_next;
        odata_reg <= odata_next;
    end

    assign sft   = ps_shift(ps_reg);
    assign in_ok = (s_axis_tdata >= min_reg) && (s_axis_tdata <= max_reg)
                   && (s_axis_tdata != '0);
    assign fit   = (quo[DIV_PROBE:0] >= (DIV_PROBE+1)'(2))
                   && (quo[DIV_PROBE:0] <= (DIV_PROBE+1)'(256));
    assign dcode = DIV_SPAN - (DIV_W+1)'(div_reg);

    always_comb
    begin
        state_next  = state_reg;
        rate_next   = rate_reg;
        ps_next     = ps_reg;
        div_next    = div_reg;
        ach_next    = ach_reg;
        fail_next   = fail_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        req.start   = 1'b0;
        req.steps   = DIV_STEPS;
        numer       = CLK_NUM + (NW'(rate_reg) << (sft - 4'd1));
        dsh         = SH_W'(rate_reg) << (5'(sft) + 5'(DIV_PROBE));
        s_axis_tready = 1'b0;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    rate_next = s_axis_tdata;
                    ps_next   = 2'd3;
                    fail_next = !in_ok;
                    state_next = in_ok ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD:
            begin
                req.start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (done)
                begin
                    if (fit)
                    begin
                        div_next   = quo[DIV_W-1:0];
                        state_next = ST_ACH_LOAD;
                    end
                    else if (ps_reg == '0)
                    begin
                        fail_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ps_next    = ps_reg - PS_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_ACH_LOAD:
            begin
                req.start  = 1'b1;
                req.steps  = ACH_STEPS;
                numer      = CLK_NUM;
                dsh        = SH_W'(div_reg) << (6'(sft) + 6'(ACH_PROBE));
                state_next = ST_ACH;
            end
            ST_ACH:
            begin
                if (done)
                begin
                    ach_next   = quo[ACH_PROBE] ? '1 : quo[ACH_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    if (fail_reg)
                        odata_next = OUT_W'(1);
                    else
                        odata_next = {1'b0, ach_reg, dcode[CODE_W-1:0],
                                      PS_FLAG | CODE_W'(ps_reg), 1'b0};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

endmodule

// File: sv/bpds_div.sv
// ----------------------------------------------------------------------------
// bpds_div
// Restoring divider, one quotient bit per cycle against a pre-aligned divisor.
// ----------------------------------------------------------------------------
module bpds_div
    import bpds_pkg::*;
#(
    parameter int NW = 36,
    parameter int SW = SH_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [NW-1:0]    numer,
    input  logic [SW-1:0]    dsh,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int CW = (NW > SW) ? NW : SW;

    logic [NW-1:0]     rem_reg;
    logic [SW-1:0]     dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [CW-1:0]     rem_ext;
    logic [CW-1:0]     dsh_ext;
    logic [CW-1:0]     diff;
    logic              ge;

    assign rem_ext = CW'(rem_reg);
    assign dsh_ext = CW'(dsh_reg);
    assign ge      = rem_ext >= dsh_ext;
    assign diff    = rem_ext - dsh_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == STEP_W'(1));
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= req.steps;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= numer;
            dsh_reg <= dsh;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            if (ge)
                rem_reg <= diff[NW-1:0];
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: sim/tb_baud_prescaler_divisor_search.sv
// ----------------------------------------------------------------------------
// tb_baud_prescaler_divisor_search
// Self-checking bench for the baud prescaler divisor search.
//
// Requested rates go in on s_axis and results come back on m_axis. Each
// accepted request is run through a local copy of the prescaler and divisor
// search, and every result is checked field by field against the oldest
// prediction. A directed set covers range limits, prescaler boundaries, a zero
// rate, rates no prescaler can reach and crossed limits. Random phases follow
// under several register settings and different amounts of sender idling and
// receiver backpressure.
// ----------------------------------------------------------------------------
module tb_baud_prescaler_divisor_search;
    import bpds_pkg::*;

    localparam longint unsigned SYS_CLOCK_HZ = DEFAULT_CLOCK_HZ;
    localparam longint unsigned ACH_MAX      = 64'h3FFFFF;
    localparam logic            STATUS_OK      = 1'b0;
    localparam logic            STATUS_INVALID = 1'b1;
    localparam logic [IDX_W-1:0] REG_SPARE_LO  = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_HI  = 2'd3;
    localparam int RESET_CYCLES  = 11;
    localparam int TAIL_CYCLES   = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 75;

    typedef struct packed {
        logic [ACH_W-1:0]  achieved_rate;
        logic [CODE_W-1:0] divisor_code;
        logic [CODE_W-1:0] prescaler_code;
        logic              status;
    } baud_result_t;

    class baud_scoreboard;
        baud_result_t      expected_q[$];
        logic [RATE_W-1:0] rate_q[$];
        logic [RATE_W-1:0] rate_min;
        logic [RATE_W-1:0] rate_max;
        int                mismatches;
        int                checked;
        int                found_count;
        int                rejected_count;

        function new();
            rate_min       = RATE_MIN_RST;
            rate_max       = RATE_MAX_RST;
            mismatches     = 0;
            checked        = 0;
            found_count    = 0;
            rejected_count = 0;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [RATE_W-1:0] val);
            if (idx == REG_RATE_MIN)
                rate_min = val;
            else if (idx == REG_RATE_MAX)
                rate_max = val;
        endfunction

        function baud_result_t search_divisor(logic [RATE_W-1:0] rate);
            baud_result_t    r;
            longint unsigned factor;
            longint unsigned fr;
            longint unsigned dv;
            longint unsigned act;
            bit              found;
            r        = '0;
            r.status = STATUS_INVALID;
            found    = 1'b0;
            if (rate == 0 || rate < rate_min || rate > rate_max)
                return r;
            for (int ps = 3; ps >= 0; ps--)
            begin
                factor = 64'd1 << (12 - 3 * ps);
                fr     = factor * rate;
                dv     = (SYS_CLOCK_HZ + fr / 2) / fr;
                if (!found && dv >= 2 && dv <= 256)
                begin
                    found = 1'b1;
                    act   = SYS_CLOCK_HZ / (factor * dv);
                    if (act > ACH_MAX)
                        act = ACH_MAX;
                    r.status         = STATUS_OK;
                    r.prescaler_code = PS_FLAG | CODE_W'(ps);
                    r.divisor_code   = CODE_W'(256 - dv);
                    r.achieved_rate  = ACH_W'(act);
                end
            end
            return r;
        endfunction

        function void note_request(logic [RATE_W-1:0] rate);
            baud_result_t r;
            r = search_divisor(rate);
            if (r.status == STATUS_OK)
                found_count++;
            else
                rejected_count++;
            expected_q.push_back(r);
            rate_q.push_back(rate);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            baud_result_t      want;
            baud_result_t      got;
            logic [RATE_W-1:0] rate;
            got = baud_result_t'(data[$bits(baud_result_t)-1:0]);
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result 0x%010h with no request pending", data);
                return;
            end
            want = expected_q.pop_front();
            rate = rate_q.pop_front();
            checked++;
            if (got.status !== want.status || got.prescaler_code !== want.prescaler_code ||
                got.divisor_code !== want.divisor_code ||
                got.achieved_rate !== want.achieved_rate)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch rate %0d: exp st %0d ps %02h div %02h ach %0d,",
                              " got st %0d ps %02h div %02h ach %0d"},
                             rate, want.status, want.prescaler_code, want.divisor_code,
                             want.achieved_rate, got.status, got.prescaler_code,
                             got.divisor_code, got.achieved_rate);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // requested_rate[23:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // status[0], prescaler_code[8:1], divisor_code[16:9], achieved_rate[38:17]
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [RATE_W-1:0] cfg_data;

    baud_scoreboard sb;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             cycle_count = 0;
    int             settings_count = 0;

    baud_prescaler_divisor_search u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, val);
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [RATE_W-1:0] lo, input logic [RATE_W-1:0] hi);
        write_register(REG_RATE_MIN, lo);
        write_register(REG_RATE_MAX, hi);
        settings_count++;
    endtask

    task automatic send_rate(input logic [RATE_W-1:0] rate);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rate;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_request(rate);
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        logic [RATE_W-1:0] common_rates[13];
        int                sel;
        common_rates = '{300, 1200, 9600, 19200, 38400, 57600, 115200, 230400,
                         460800, 921600, 1000000, 2000000, 3000000};
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return RATE_W'($urandom_range(40, 400));
        else if (sel < 30)
            return RATE_W'($urandom_range(300, 4000));
        else if (sel < 45)
            return RATE_W'($urandom_range(3000, 30000));
        else if (sel < 65)
            return RATE_W'($urandom_range(20000, 4100000));
        else if (sel < 75)
            return RATE_W'($urandom);
        else if (sel < 82)
            return sb.rate_min + RATE_W'($urandom_range(0, 4)) - RATE_W'(2);
        else if (sel < 90)
            return sb.rate_max + RATE_W'($urandom_range(0, 4)) - RATE_W'(2);
        else
            return common_rates[$urandom_range(0, 12)];
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit hold_mid);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (hold_mid && i == PHASE_ITEMS / 2)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drain();
            end
            send_rate(pick_rate());
        end
        s_axis_tvalid <= 1'b0;
        wait_drain();
    endtask

    initial
    begin
        logic [RATE_W-1:0] lo;
        logic [RATE_W-1:0] hi;
        sb            = new;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits, no backpressure
        send_rate(50);
        send_rate(49);
        send_rate(3000000);
        send_rate(3000001);
        send_rate(0);
        send_rate(24'hFFFFFF);
        send_rate(9600);
        send_rate(115200);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        // widest limits: zero rate, unreachable rates, prescaler boundaries
        write_register(REG_SPARE_LO, 24'hFFFFFF);
        set_limits(24'd0, 24'hFFFFFF);
        write_register(REG_SPARE_HI, 24'h000001);
        send_rate(0);
        send_rate(1);
        send_rate(45);
        send_rate(46);
        send_rate(24'hFFFFFF);
        send_rate(4000000);
        send_rate(4000001);
        send_rate(23438);
        send_rate(23000);
        send_rate(2930);
        send_rate(366);
        send_rate(24'h800000);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        // crossed limits reject everything
        set_limits(24'd1000, 24'd999);
        send_rate(1000);
        send_rate(999);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        set_limits(24'd1, 24'd1);
        send_rate(1);
        send_rate(2);
        s_axis_tvalid <= 1'b0;
        wait_drain();

        set_limits(RATE_MIN_RST, RATE_MAX_RST);
        run_phase(0, 0, 1'b0);

        lo = RATE_W'($urandom_range(0, 100));
        hi = RATE_W'($urandom_range(2000000, 24'hFFFFFF));
        set_limits(lo, hi);
        run_phase(52, 0, 1'b1);

        set_limits(24'd0, 24'hFFFFFF);
        run_phase(0, 52, 1'b0);

        lo = RATE_W'($urandom_range(0, 5000));
        hi = RATE_W'($urandom_range(100000, 4000000));
        set_limits(lo, hi);
        run_phase(18, 18, 1'b0);

        lo = RATE_W'($urandom);
        hi = RATE_W'($urandom);
        set_limits(lo, hi);
        run_phase(52, 52, 1'b0);

        lo = RATE_W'($urandom_range(1, 300));
        hi = RATE_W'($urandom_range(500000, 24'hFFFFFF));
        set_limits(lo, hi);
        run_phase(0, 0, 1'b1);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results under %0d register settings: %0d mapped, %0d rejected",
                 sb.checked, settings_count, sb.found_count, sb.rejected_count);
        $display("Mismatches: %0d, results still outstanding: %0d",
                 sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
